// ----- hdl/utf8d_pkg.sv -----
// ============================================================================
// UTF-8 strict decoder package
// Widths and byte-range constants shared by the decoder and its channels.
// ============================================================================
package utf8d_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int USED_W = 3;
   localparam int CNT_W  = 2;

   localparam logic [CP_W-1:0]   REPL_CP   = 21'h00FFFD;
   localparam logic [BYTE_W-1:0] ASCII_END = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_LO   = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_HI   = 8'hBF;
   localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD2_HI  = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_HI  = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD4_LO  = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_HI  = 8'hF4;
   localparam logic [BYTE_W-1:0] LEAD_E0   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_ED   = 8'hED;
   localparam logic [BYTE_W-1:0] LEAD_F0   = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD_F4   = 8'hF4;
   localparam logic [BYTE_W-1:0] E0_LO     = 8'hA0;
   localparam logic [BYTE_W-1:0] ED_HI     = 8'h9F;
   localparam logic [BYTE_W-1:0] F0_LO     = 8'h90;
   localparam logic [BYTE_W-1:0] F4_HI     = 8'h8F;

   localparam logic [USED_W-1:0] LEN_1 = 3'd1;
   localparam logic [USED_W-1:0] LEN_2 = 3'd2;
   localparam logic [USED_W-1:0] LEN_3 = 3'd3;
   localparam logic [USED_W-1:0] LEN_4 = 3'd4;

endpackage

// ----- hdl/utf8d_req_if.sv -----
// ============================================================================
// UTF-8 decoder input channel
// Valid/ready channel carrying one text byte and its end-of-text flag.
// ============================================================================
interface utf8d_req_if;
   logic                           valid;
   logic                           ready;
   logic [utf8d_pkg::BYTE_W-1:0]   text_byte;
   logic                           end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- hdl/utf8d_rsp_if.sv -----
// ============================================================================
// UTF-8 decoder result channel
// Valid/ready channel carrying one decoded code point per beat.
// ============================================================================
interface utf8d_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [utf8d_pkg::CP_W-1:0]     code_point;
   logic                           is_replacement;
   logic [utf8d_pkg::USED_W-1:0]   bytes_used;
   logic                           last_of_run;

   modport source (output valid, output code_point, output is_replacement,
                   output bytes_used, output last_of_run, input ready);
   modport sink   (input valid, input code_point, input is_replacement,
                   input bytes_used, input last_of_run, output ready);
endinterface

// ----- hdl/utf8_strict_decoder_core.sv -----
// ============================================================================
// UTF-8 strict decoder core
// Streaming RFC 3629 decoder: one byte per input beat, code points out.
// ============================================================================
// The req channel takes one text byte per beat with an end-of-text flag on
// the final byte. The rsp channel returns the results that each byte causes,
// one per beat, with last_of_run marking the final result of a byte.
// A byte produces zero to four results: a broken prefix is flushed as one
// U+FFFD per held byte, then the byte is decoded as a new lead, and an
// end-of-text flag flushes whatever prefix is still pending.
// The byte is decoded against the prefix state in the cycle it is taken and
// its whole run is written into the result register, so the first result is
// visible in the cycle after the input beat. Further results of the same
// run leave one at a time through the single result port.
// A new byte is taken while the last result of the previous run is being
// taken, so a stream that yields at most one result per byte runs at one
// byte per cycle while the receiver stays ready. When the receiver stalls,
// the result register holds and req.ready falls once a run is waiting.
// Reset clears the pending prefix and drops any results not yet delivered.
// ============================================================================
module utf8_strict_decoder_core (
   input  logic              clock,
   input  logic              reset,
   utf8d_req_if.sink         req_chan,
   utf8d_rsp_if.source       rsp_chan
);

   logic [utf8d_pkg::CNT_W-1:0]  pend_ff, pend_in;
   logic [utf8d_pkg::USED_W-1:0] exp_ff, exp_in;
   logic [utf8d_pkg::BYTE_W-1:0] lead_ff, lead_in;
   logic [utf8d_pkg::CP_W-1:0]   part_ff, part_in;

   logic [utf8d_pkg::CNT_W-1:0]  before_ff, before_in;
   logic                         item_ff, item_in;
   logic [utf8d_pkg::CP_W-1:0]   item_cp_ff, item_cp_in;
   logic                         item_repl_ff, item_repl_in;
   logic [utf8d_pkg::USED_W-1:0] item_used_ff, item_used_in;
   logic [utf8d_pkg::CNT_W-1:0]  after_ff, after_in;

   logic [2:0]                   left;
   logic                         accept;
   logic                         pop;

   logic [utf8d_pkg::BYTE_W-1:0] b;
   logic [utf8d_pkg::BYTE_W-1:0] lo;
   logic [utf8d_pkg::BYTE_W-1:0] hi;
   logic                         ok;
   logic                         taken;
   logic [utf8d_pkg::CNT_W-1:0]  cnt_next;
   logic [utf8d_pkg::CP_W-1:0]   part_next;
   logic                         complete;
   logic [utf8d_pkg::CNT_W-1:0]  new_before;
   logic                         new_item;
   logic [utf8d_pkg::CP_W-1:0]   new_cp;
   logic                         new_repl;
   logic [utf8d_pkg::USED_W-1:0] new_used;
   logic [utf8d_pkg::CNT_W-1:0]  new_after;
   logic [utf8d_pkg::CNT_W-1:0]  st_pend;
   logic [utf8d_pkg::USED_W-1:0] st_exp;
   logic [utf8d_pkg::BYTE_W-1:0] st_lead;
   logic [utf8d_pkg::CP_W-1:0]   st_part;

   assign left = {1'b0, before_ff} + {2'b00, item_ff} + {1'b0, after_ff};
   assign rsp_chan.valid = (left != 3'd0);
   assign pop = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (left == 3'd0) || ((left == 3'd1) && rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      b  = req_chan.text_byte;
      lo = utf8d_pkg::CONT_LO;
      hi = utf8d_pkg::CONT_HI;
      if (pend_ff == 2'd1) begin
         unique case (lead_ff)
            utf8d_pkg::LEAD_E0: lo = utf8d_pkg::E0_LO;
            utf8d_pkg::LEAD_ED: hi = utf8d_pkg::ED_HI;
            utf8d_pkg::LEAD_F0: lo = utf8d_pkg::F0_LO;
            utf8d_pkg::LEAD_F4: hi = utf8d_pkg::F4_HI;
            default: ;
         endcase
      end
      ok        = (b >= lo) && (b <= hi);
      taken     = (pend_ff != 2'd0) && ok;
      cnt_next  = pend_ff + 2'd1;
      part_next = {part_ff[utf8d_pkg::CP_W-7:0], b[5:0]};
      complete  = (cnt_next == 2'd0) || ({1'b0, cnt_next} >= exp_ff);

      new_before = ((pend_ff != 2'd0) && !ok) ? pend_ff : 2'd0;
      new_item   = 1'b0;
      new_cp     = utf8d_pkg::REPL_CP;
      new_repl   = 1'b1;
      new_used   = utf8d_pkg::LEN_1;
      st_pend    = 2'd0;
      st_exp     = 3'd0;
      st_lead    = '0;
      st_part    = '0;

      if (taken) begin
         if (complete) begin
            new_item = 1'b1;
            new_cp   = part_next;
            new_repl = 1'b0;
            new_used = exp_ff;
         end else begin
            st_pend = cnt_next;
            st_exp  = exp_ff;
            st_lead = lead_ff;
            st_part = part_next;
         end
      end else if (b < utf8d_pkg::ASCII_END) begin
         new_item = 1'b1;
         new_cp   = {13'd0, b};
         new_repl = 1'b0;
      end else if ((b >= utf8d_pkg::LEAD2_LO) && (b <= utf8d_pkg::LEAD2_HI)) begin
         st_pend = 2'd1;
         st_exp  = utf8d_pkg::LEN_2;
         st_lead = b;
         st_part = {16'd0, b[4:0]};
      end else if ((b >= utf8d_pkg::LEAD3_LO) && (b <= utf8d_pkg::LEAD3_HI)) begin
         st_pend = 2'd1;
         st_exp  = utf8d_pkg::LEN_3;
         st_lead = b;
         st_part = {17'd0, b[3:0]};
      end else if ((b >= utf8d_pkg::LEAD4_LO) && (b <= utf8d_pkg::LEAD4_HI)) begin
         st_pend = 2'd1;
         st_exp  = utf8d_pkg::LEN_4;
         st_lead = b;
         st_part = {18'd0, b[2:0]};
      end else begin
         new_item = 1'b1;
      end

      new_after = 2'd0;
      if (req_chan.end_of_text && (st_pend != 2'd0)) begin
         new_after = st_pend;
         st_pend   = 2'd0;
         st_exp    = 3'd0;
         st_lead   = '0;
         st_part   = '0;
      end
   end

   always_comb begin
      pend_in      = pend_ff;
      exp_in       = exp_ff;
      lead_in      = lead_ff;
      part_in      = part_ff;
      before_in    = before_ff;
      item_in      = item_ff;
      item_cp_in   = item_cp_ff;
      item_repl_in = item_repl_ff;
      item_used_in = item_used_ff;
      after_in     = after_ff;
      if (accept) begin
         pend_in      = st_pend;
         exp_in       = st_exp;
         lead_in      = st_lead;
         part_in      = st_part;
         before_in    = new_before;
         item_in      = new_item;
         item_cp_in   = new_cp;
         item_repl_in = new_repl;
         item_used_in = new_used;
         after_in     = new_after;
      end else if (pop) begin
         if (before_ff != 2'd0) begin
            before_in = before_ff - 2'd1;
         end else if (item_ff) begin
            item_in = 1'b0;
         end else begin
            after_in = after_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         exp_ff    <= '0;
         lead_ff   <= '0;
         part_ff   <= '0;
         before_ff <= '0;
         item_ff   <= 1'b0;
         after_ff  <= '0;
      end else begin
         pend_ff   <= pend_in;
         exp_ff    <= exp_in;
         lead_ff   <= lead_in;
         part_ff   <= part_in;
         before_ff <= before_in;
         item_ff   <= item_in;
         after_ff  <= after_in;
      end
   end

   always_ff @(posedge clock) begin
      item_cp_ff   <= item_cp_in;
      item_repl_ff <= item_repl_in;
      item_used_ff <= item_used_in;
   end

   always_comb begin
      if ((before_ff == 2'd0) && item_ff) begin
         rsp_chan.code_point     = item_cp_ff;
         rsp_chan.is_replacement = item_repl_ff;
         rsp_chan.bytes_used     = item_used_ff;
      end else begin
         rsp_chan.code_point     = utf8d_pkg::REPL_CP;
         rsp_chan.is_replacement = 1'b1;
         rsp_chan.bytes_used     = utf8d_pkg::LEN_1;
      end
      rsp_chan.last_of_run = (left == 3'd1);
   end

   // A pending prefix always has fewer bytes than its full sequence length.
   assert property (@(posedge clock) disable iff (reset)
      (pend_ff != 2'd0) |-> ({1'b0, pend_ff} < exp_ff))
      else $error("pending prefix is not shorter than its sequence");

   // An end-of-text byte leaves no prefix behind.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_text) |=> (pend_ff == 2'd0))
      else $error("prefix left pending after end of text");

   // No new byte is taken while more than one result of a run is waiting.
   assert property (@(posedge clock) disable iff (reset)
      (left > 3'd1) |-> !req_chan.ready)
      else $error("input taken while a run is still queued");

   // An ASCII byte with no prefix pending comes out as itself in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (pend_ff == 2'd0) && (req_chan.text_byte < utf8d_pkg::ASCII_END))
      |=> (rsp_chan.valid && (rsp_chan.code_point == {13'd0, $past(req_chan.text_byte)})))
      else $error("ASCII byte not passed through");

endmodule

// ----- tb/sv/utf8_strict_decoder_core_tb.sv -----
// ============================================================================
// UTF-8 strict decoder core testbench
// Streams a short table of boundary bytes and then random text, mostly
// well-formed sequences with broken prefixes and noise mixed in, through
// the decoder with random idling on both channels. Each result is checked
// field by field against a scoreboard fed by the table or a decoder model.
// ============================================================================
module utf8_strict_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [utf8d_pkg::CP_W-1:0]   cp;
      logic                         repl;
      logic [utf8d_pkg::USED_W-1:0] used;
      logic                         last;
   } cp_result_type;

   typedef struct packed {
      logic [utf8d_pkg::BYTE_W-1:0] b;
      logic                         eot;
      logic                         typed;
      logic [utf8d_pkg::CP_W-1:0]   cp;
      logic                         repl;
      logic [utf8d_pkg::USED_W-1:0] used;
   } text_row_type;

   localparam int DIRECTED_LEN = 27;
   localparam int RANDOM_BEATS = 243;
   localparam int CALM_TAIL    = 40;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;

   localparam text_row_type DIRECTED_ROWS [0:DIRECTED_LEN-1] = '{
      '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0, utf8d_pkg::LEN_1},
      '{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0, utf8d_pkg::LEN_1},
      '{8'h80, 1'b0, 1'b1, utf8d_pkg::REPL_CP, 1'b1, utf8d_pkg::LEN_1},
      '{8'hFF, 1'b0, 1'b1, utf8d_pkg::REPL_CP, 1'b1, utf8d_pkg::LEN_1},
      '{8'hC0, 1'b0, 1'b1, utf8d_pkg::REPL_CP, 1'b1, utf8d_pkg::LEN_1},
      '{8'hF5, 1'b0, 1'b1, utf8d_pkg::REPL_CP, 1'b1, utf8d_pkg::LEN_1},
      '{8'hC2, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'h80, 1'b0, 1'b1, 21'h000080, 1'b0, utf8d_pkg::LEN_2},
      '{8'hE0, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'hA0, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'h80, 1'b0, 1'b1, 21'h000800, 1'b0, utf8d_pkg::LEN_3},
      '{8'hE0, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'h9F, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'hED, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'hA0, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'hF0, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'h8F, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'hF4, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'h8F, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'hBF, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'hBF, 1'b0, 1'b1, 21'h10FFFF, 1'b0, utf8d_pkg::LEN_4},
      '{8'hF4, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'h90, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'hF1, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'h80, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'h80, 1'b1, 1'b0, 21'h0,      1'b0, 3'd0},
      '{8'hC3, 1'b1, 1'b0, 21'h0,      1'b0, 3'd0}
   };

   logic clock;
   logic reset;

   utf8d_req_if req_if();
   utf8d_rsp_if rsp_if();

   utf8_strict_decoder_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   text_row_type  text_beats [$];
   cp_result_type expected_cps [$];
   cp_result_type predicted_run [$];

   logic [utf8d_pkg::CNT_W-1:0]  pend_cnt  = '0;
   logic [utf8d_pkg::USED_W-1:0] pend_len  = '0;
   logic [utf8d_pkg::BYTE_W-1:0] pend_lead = '0;
   logic [utf8d_pkg::CP_W-1:0]   pend_code = '0;

   int  fail_count   = 0;
   int  accepted_idx = 0;
   int  stuck_cycles = 0;
   bit  calm         = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_cp(input logic [utf8d_pkg::CP_W-1:0] cp, input logic repl,
                                   input logic [utf8d_pkg::USED_W-1:0] used);
      predicted_run.push_back('{cp, repl, used, 1'b0});
   endfunction

   function automatic void clear_pending();
      pend_cnt  = '0;
      pend_len  = '0;
      pend_lead = '0;
      pend_code = '0;
   endfunction

   function automatic void flush_pending();
      for (int k = 0; k < pend_cnt; k++)
         push_cp(utf8d_pkg::REPL_CP, 1'b1, utf8d_pkg::LEN_1);
      clear_pending();
   endfunction

   function automatic void set_pending(input logic [utf8d_pkg::USED_W-1:0] len,
                                       input logic [utf8d_pkg::BYTE_W-1:0] lead,
                                       input logic [utf8d_pkg::CP_W-1:0] bits);
      pend_cnt  = 2'd1;
      pend_len  = len;
      pend_lead = lead;
      pend_code = bits;
   endfunction

   // Decodes one text byte against the held prefix and leaves its results
   // in predicted_run.
   function automatic void predict_run(input logic [utf8d_pkg::BYTE_W-1:0] b,
                                       input logic eot);
      logic [utf8d_pkg::BYTE_W-1:0] lo;
      logic [utf8d_pkg::BYTE_W-1:0] hi;
      logic                         taken;
      predicted_run.delete();
      taken = 1'b0;
      if (pend_cnt != 0) begin
         lo = utf8d_pkg::CONT_LO;
         hi = utf8d_pkg::CONT_HI;
         if (pend_cnt == 2'd1) begin
            if (pend_lead == utf8d_pkg::LEAD_E0) lo = utf8d_pkg::E0_LO;
            else if (pend_lead == utf8d_pkg::LEAD_ED) hi = utf8d_pkg::ED_HI;
            else if (pend_lead == utf8d_pkg::LEAD_F0) lo = utf8d_pkg::F0_LO;
            else if (pend_lead == utf8d_pkg::LEAD_F4) hi = utf8d_pkg::F4_HI;
         end
         if (b >= lo && b <= hi) begin
            pend_code = {pend_code[utf8d_pkg::CP_W-7:0], b[5:0]};
            pend_cnt  = pend_cnt + 2'd1;
            if (pend_cnt == 0 || {1'b0, pend_cnt} >= pend_len) begin
               push_cp(pend_code, 1'b0, pend_len);
               clear_pending();
            end
            taken = 1'b1;
         end else begin
            flush_pending();
         end
      end
      if (!taken) begin
         if (b < utf8d_pkg::ASCII_END)
            push_cp({13'd0, b}, 1'b0, utf8d_pkg::LEN_1);
         else if (b >= utf8d_pkg::LEAD2_LO && b <= utf8d_pkg::LEAD2_HI)
            set_pending(utf8d_pkg::LEN_2, b, {16'd0, b[4:0]});
         else if (b >= utf8d_pkg::LEAD3_LO && b <= utf8d_pkg::LEAD3_HI)
            set_pending(utf8d_pkg::LEN_3, b, {17'd0, b[3:0]});
         else if (b >= utf8d_pkg::LEAD4_LO && b <= utf8d_pkg::LEAD4_HI)
            set_pending(utf8d_pkg::LEN_4, b, {18'd0, b[2:0]});
         else
            push_cp(utf8d_pkg::REPL_CP, 1'b1, utf8d_pkg::LEN_1);
      end
      if (eot && pend_cnt != 0) flush_pending();
      if (predicted_run.size() != 0) predicted_run[predicted_run.size()-1].last = 1'b1;
   endfunction

   task automatic add_text_byte(input logic [utf8d_pkg::BYTE_W-1:0] b);
      text_beats.push_back('{b, ($urandom_range(0, 19) == 0), 1'b0, '0, 1'b0, '0});
   endtask

   task automatic build_random_text();
      int                           kind;
      int                           n;
      int                           k;
      logic [utf8d_pkg::BYTE_W-1:0] seq [4];
      logic [utf8d_pkg::BYTE_W-1:0] lo;
      logic [utf8d_pkg::BYTE_W-1:0] hi;
      while (text_beats.size() < DIRECTED_LEN + RANDOM_BEATS) begin
         kind = $urandom_range(0, 9);
         n    = $urandom_range(2, 4);
         case (n)
            2: seq[0] = 8'($urandom_range(utf8d_pkg::LEAD2_LO, utf8d_pkg::LEAD2_HI));
            3: seq[0] = 8'($urandom_range(utf8d_pkg::LEAD3_LO, utf8d_pkg::LEAD3_HI));
            default: seq[0] = 8'($urandom_range(utf8d_pkg::LEAD4_LO, utf8d_pkg::LEAD4_HI));
         endcase
         lo = utf8d_pkg::CONT_LO;
         hi = utf8d_pkg::CONT_HI;
         if (seq[0] == utf8d_pkg::LEAD_E0) lo = utf8d_pkg::E0_LO;
         else if (seq[0] == utf8d_pkg::LEAD_ED) hi = utf8d_pkg::ED_HI;
         else if (seq[0] == utf8d_pkg::LEAD_F0) lo = utf8d_pkg::F0_LO;
         else if (seq[0] == utf8d_pkg::LEAD_F4) hi = utf8d_pkg::F4_HI;
         seq[1] = 8'($urandom_range(lo, hi));
         seq[2] = 8'($urandom_range(utf8d_pkg::CONT_LO, utf8d_pkg::CONT_HI));
         seq[3] = 8'($urandom_range(utf8d_pkg::CONT_LO, utf8d_pkg::CONT_HI));
         if (kind <= 2) begin
            add_text_byte(8'($urandom_range(0, 127)));
         end else if (kind <= 6) begin
            for (int j = 0; j < n; j++) add_text_byte(seq[j]);
         end else if (kind == 7) begin
            add_text_byte(8'($urandom_range(0, 255)));
         end else if (kind == 8) begin
            k = $urandom_range(1, n - 1);
            for (int j = 0; j < k; j++) add_text_byte(seq[j]);
            add_text_byte(8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  seq[0] = utf8d_pkg::LEAD_E0;
                  seq[1] = 8'($urandom_range(utf8d_pkg::CONT_LO, utf8d_pkg::E0_LO - 8'd1));
               end
               1: begin
                  seq[0] = utf8d_pkg::LEAD_ED;
                  seq[1] = 8'($urandom_range(utf8d_pkg::ED_HI + 8'd1, utf8d_pkg::CONT_HI));
               end
               2: begin
                  seq[0] = utf8d_pkg::LEAD_F0;
                  seq[1] = 8'($urandom_range(utf8d_pkg::CONT_LO, utf8d_pkg::F0_LO - 8'd1));
               end
               default: begin
                  seq[0] = utf8d_pkg::LEAD_F4;
                  seq[1] = 8'($urandom_range(utf8d_pkg::F4_HI + 8'd1, utf8d_pkg::CONT_HI));
               end
            endcase
            add_text_byte(seq[0]);
            add_text_byte(seq[1]);
         end
      end
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= 40)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   initial begin : drive_text
      int idx;
      int gap;
      idx                 = 0;
      req_if.valid        = 1'b0;
      req_if.text_byte    = '0;
      req_if.end_of_text  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      while (idx < text_beats.size()) begin
         calm = (text_beats.size() - idx) <= CALM_TAIL;
         if (!calm && $urandom_range(0, 4) == 0) begin
            gap          = $urandom_range(1, 8);
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_if.valid       = 1'b1;
         req_if.text_byte   = text_beats[idx].b;
         req_if.end_of_text = text_beats[idx].eot;
         do @(posedge clock); while (!req_if.ready);
         idx++;
         @(negedge clock);
      end
      req_if.valid = 1'b0;
   end

   initial begin : drive_sink
      int stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready = 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left   = $urandom_range(1, 8) - 1;
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cp_result_type want;
      text_row_type  row;
      if (!reset) begin
         stuck_cycles++;
         if (rsp_if.valid && rsp_if.ready) begin
            stuck_cycles = 0;
            if (expected_cps.size() == 0) begin
               fail_count++;
               if (fail_count <= 40)
                  $display("%0t: unexpected result beat, expected none, actual cp=%h",
                           $time, rsp_if.code_point);
            end else begin
               want = expected_cps.pop_front();
               check_field("code_point", want.cp, rsp_if.code_point);
               check_field("is_replacement", want.repl, rsp_if.is_replacement);
               check_field("bytes_used", want.used, rsp_if.bytes_used);
               check_field("last_of_run", want.last, rsp_if.last_of_run);
            end
         end
         if (req_if.valid && req_if.ready) begin
            stuck_cycles = 0;
            row = text_beats[accepted_idx];
            predict_run(row.b, row.eot);
            if (row.typed) begin
               expected_cps.push_back('{row.cp, row.repl, row.used, 1'b1});
            end else begin
               foreach (predicted_run[i]) expected_cps.push_back(predicted_run[i]);
            end
            accepted_idx++;
         end
         if (stuck_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      foreach (DIRECTED_ROWS[i]) text_beats.push_back(DIRECTED_ROWS[i]);
      build_random_text();
      repeat (11) @(negedge clock);
      reset = 1'b0;
      while (accepted_idx < text_beats.size() || expected_cps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_cps.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
